FILE: hw/rtl/sed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

  // escape decoder modes, one-hot
  typedef enum logic [5:0] {
    MODE_PLAIN = 6'b000001,
    MODE_ESC   = 6'b000010,
    MODE_HEX   = 6'b000100,
    MODE_OCT   = 6'b001000,
    MODE_U4    = 6'b010000,
    MODE_U8    = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNTERM    = 3'd1,
    ERR_UNTERM_ESC = 3'd2,
    ERR_BAD_HEX   = 3'd3,
    ERR_BAD_OCT   = 3'd4,
    ERR_BAD_U4    = 3'd5,
    ERR_BAD_U8    = 3'd6,
    ERR_UNKNOWN   = 3'd7
  } err_t;

  localparam logic       ACT_BYTE = 1'b0;
  localparam logic       ACT_END  = 1'b1;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_UC_U   = 8'h55;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_THREE  = 8'h33;

  localparam logic [7:0] VAL_BEL = 8'h07;
  localparam logic [7:0] VAL_BS  = 8'h08;
  localparam logic [7:0] VAL_FF  = 8'h0C;
  localparam logic [7:0] VAL_LF  = 8'h0A;
  localparam logic [7:0] VAL_CR  = 8'h0D;
  localparam logic [7:0] VAL_TAB = 8'h09;
  localparam logic [7:0] VAL_VT  = 8'h0B;

  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] CP_SUR_LO  = 32'h0000_D800;
  localparam logic [31:0] CP_SUR_HI  = 32'h0000_DFFF;
  localparam logic [31:0] CP_1B_MAX  = 32'h0000_007F;
  localparam logic [31:0] CP_2B_MAX  = 32'h0000_07FF;
  localparam logic [31:0] CP_3B_MAX  = 32'h0000_FFFF;

  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_CONT  = 8'h80;

  // bit 4 flags a valid hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/string_escape_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_action, in_byte
// out      output     out_valid / out_stall out_kind, out_byte, out_error_code, out_last
//
// one input beat per cycle while in_stall is low; an item's result is loaded from
// the decode register into the result register. a \u or \U escape may give up to
// four utf-8 beats, sent one per cycle from the result register while out_stall is
// low; the decode register holds the next item until the last of them is taken.
// rst_n is synchronous, active low; it clears the valid flags and the escape state.
// in_stall is a registered flag: it rises only when the skid stage holds a beat.

module string_escape_decoder
  import sed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_action,
  input  wire logic [7:0] in_byte,

  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_error_code,
  output logic            out_last
);

  // skid stage: catches the beat taken while the decode register cannot move
  logic       skid_vld_r, skid_vld_nxt;
  logic       skid_act_r;
  logic [7:0] skid_byte_r;

  // decode register
  logic       p_vld_r, p_vld_nxt;
  logic       p_act_r, p_act_nxt;
  logic [7:0] p_byte_r, p_byte_nxt;

  // escape state
  mode_t       mode_r, mode_nxt;
  logic [2:0]  digits_r, digits_nxt;
  logic [31:0] acc_r, acc_nxt;

  // result group register, beat 0 is the one on the port
  logic [2:0]  g_cnt_r;
  kind_t       g_kind_r;
  err_t        g_err_r;
  logic [7:0]  g_b_r [4];

  // decode results
  logic [2:0]  dec_n;
  kind_t       dec_kind;
  err_t        dec_err;
  logic [7:0]  dec_b [4];

  logic        in_acc, out_acc, g_free, p_go;
  logic [4:0]  hv;
  logic [2:0]  d_inc;
  logic [31:0] cp;
  logic        u_done, is_oct;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;

  assign out_valid      = (g_cnt_r != 3'd0);
  assign out_acc        = out_valid && !out_stall;
  assign out_kind       = g_kind_r;
  assign out_byte       = g_b_r[0];
  assign out_error_code = g_err_r;
  assign out_last       = (g_cnt_r == 3'd1);

  // the group register can take a new item when it is empty or drains this cycle
  assign g_free = (g_cnt_r == 3'd0) || (g_cnt_r == 3'd1 && !out_stall);
  assign p_go   = p_vld_r && g_free;

  // input side: decode register is refilled from skid first, then from the port
  always_comb begin
    p_vld_nxt    = p_vld_r;
    p_act_nxt    = p_act_r;
    p_byte_nxt   = p_byte_r;
    skid_vld_nxt = skid_vld_r;
    if (!p_vld_r || p_go) begin
      if (skid_vld_r) begin
        p_vld_nxt    = 1'b1;
        p_act_nxt    = skid_act_r;
        p_byte_nxt   = skid_byte_r;
        skid_vld_nxt = 1'b0;
      end else begin
        p_vld_nxt  = in_acc;
        p_act_nxt  = in_action;
        p_byte_nxt = in_byte;
      end
    end else if (in_acc) begin
      skid_vld_nxt = 1'b1;
    end
  end

  assign hv     = hex_val(p_byte_r);
  assign d_inc  = digits_r + 3'd1;
  assign cp     = {acc_r[27:0], hv[3:0]};
  assign is_oct = (p_byte_r[7:3] == 5'b00110);
  // \U wraps the 3-bit digit count to zero on its eighth digit
  assign u_done = (mode_r == MODE_U4) ? (d_inc == 3'd4) : (d_inc == 3'd0);

  // one item's decode
  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    acc_nxt    = acc_r;
    dec_n      = 3'd0;
    dec_kind   = KIND_BYTE;
    dec_err    = ERR_NONE;
    dec_b[0]   = 8'd0;
    dec_b[1]   = 8'd0;
    dec_b[2]   = 8'd0;
    dec_b[3]   = 8'd0;

    if (p_act_r == ACT_END) begin
      mode_nxt   = MODE_PLAIN;
      digits_nxt = 3'd0;
      acc_nxt    = 32'd0;
      dec_n      = 3'd1;
      dec_kind   = KIND_ERROR;
      unique case (mode_r)
        MODE_ESC: dec_err = ERR_UNTERM_ESC;
        MODE_HEX: dec_err = ERR_BAD_HEX;
        MODE_OCT: dec_err = ERR_BAD_OCT;
        MODE_U4:  dec_err = ERR_BAD_U4;
        MODE_U8:  dec_err = ERR_BAD_U8;
        default:  dec_err = ERR_UNTERM;
      endcase
    end else begin
      unique case (mode_r)
        MODE_ESC: begin
          digits_nxt = 3'd0;
          acc_nxt    = 32'd0;
          mode_nxt   = MODE_PLAIN;
          dec_n      = 3'd1;
          unique case (p_byte_r) inside
            CH_DQUOTE, CH_BSLASH, CH_SQUOTE, CH_QMARK: dec_b[0] = p_byte_r;
            CH_LC_A: dec_b[0] = VAL_BEL;
            CH_LC_B: dec_b[0] = VAL_BS;
            CH_LC_F: dec_b[0] = VAL_FF;
            CH_LC_N: dec_b[0] = VAL_LF;
            CH_LC_R: dec_b[0] = VAL_CR;
            CH_LC_T: dec_b[0] = VAL_TAB;
            CH_LC_V: dec_b[0] = VAL_VT;
            CH_LC_X: begin
              mode_nxt = MODE_HEX;
              dec_n    = 3'd0;
            end
            CH_ZERO, CH_ONE, CH_TWO, CH_THREE: begin
              mode_nxt = MODE_OCT;
              acc_nxt  = {30'd0, p_byte_r[1:0]};
              dec_n    = 3'd0;
            end
            CH_LC_U: begin
              mode_nxt = MODE_U4;
              dec_n    = 3'd0;
            end
            CH_UC_U: begin
              mode_nxt = MODE_U8;
              dec_n    = 3'd0;
            end
            default: begin
              dec_kind = KIND_ERROR;
              dec_err  = ERR_UNKNOWN;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hv[4]) begin
            mode_nxt   = MODE_PLAIN;
            digits_nxt = 3'd0;
            acc_nxt    = 32'd0;
            dec_n      = 3'd1;
            dec_kind   = KIND_ERROR;
            dec_err    = ERR_BAD_HEX;
          end else if (d_inc >= 3'd2) begin
            mode_nxt   = MODE_PLAIN;
            digits_nxt = 3'd0;
            acc_nxt    = 32'd0;
            dec_n      = 3'd1;
            dec_b[0]   = {acc_r[3:0], hv[3:0]};
          end else begin
            digits_nxt = d_inc;
            acc_nxt    = {acc_r[27:0], hv[3:0]};
          end
        end
        MODE_OCT: begin
          if (!is_oct) begin
            mode_nxt   = MODE_PLAIN;
            digits_nxt = 3'd0;
            acc_nxt    = 32'd0;
            dec_n      = 3'd1;
            dec_kind   = KIND_ERROR;
            dec_err    = ERR_BAD_OCT;
          end else if (d_inc >= 3'd2) begin
            mode_nxt   = MODE_PLAIN;
            digits_nxt = 3'd0;
            acc_nxt    = 32'd0;
            dec_n      = 3'd1;
            dec_b[0]   = {acc_r[4:0], p_byte_r[2:0]};
          end else begin
            digits_nxt = d_inc;
            acc_nxt    = {acc_r[28:0], p_byte_r[2:0]};
          end
        end
        MODE_U4, MODE_U8: begin
          if (!hv[4] || u_done) begin
            mode_nxt   = MODE_PLAIN;
            digits_nxt = 3'd0;
            acc_nxt    = 32'd0;
          end else begin
            digits_nxt = d_inc;
            acc_nxt    = cp;
          end
          if (!hv[4] || (u_done && (cp > CP_MAX ||
                                    (cp >= CP_SUR_LO && cp <= CP_SUR_HI)))) begin
            dec_n    = 3'd1;
            dec_kind = KIND_ERROR;
            dec_err  = (mode_r == MODE_U4) ? ERR_BAD_U4 : ERR_BAD_U8;
          end else if (u_done) begin
            // utf-8 encode of the finished code point
            if (cp <= CP_1B_MAX) begin
              dec_n    = 3'd1;
              dec_b[0] = cp[7:0];
            end else if (cp <= CP_2B_MAX) begin
              dec_n    = 3'd2;
              dec_b[0] = UTF_LEAD2 | {3'd0, cp[10:6]};
              dec_b[1] = UTF_CONT | {2'd0, cp[5:0]};
            end else if (cp <= CP_3B_MAX) begin
              dec_n    = 3'd3;
              dec_b[0] = UTF_LEAD3 | {4'd0, cp[15:12]};
              dec_b[1] = UTF_CONT | {2'd0, cp[11:6]};
              dec_b[2] = UTF_CONT | {2'd0, cp[5:0]};
            end else begin
              dec_n    = 3'd4;
              dec_b[0] = UTF_LEAD4 | {5'd0, cp[20:18]};
              dec_b[1] = UTF_CONT | {2'd0, cp[17:12]};
              dec_b[2] = UTF_CONT | {2'd0, cp[11:6]};
              dec_b[3] = UTF_CONT | {2'd0, cp[5:0]};
            end
          end
        end
        default: begin
          // plain body
          if (p_byte_r == CH_DQUOTE) begin
            mode_nxt   = MODE_PLAIN;
            digits_nxt = 3'd0;
            acc_nxt    = 32'd0;
            dec_n      = 3'd1;
            dec_kind   = KIND_CLOSE;
          end else if (p_byte_r == CH_BSLASH) begin
            mode_nxt   = MODE_ESC;
            digits_nxt = 3'd0;
            acc_nxt    = 32'd0;
          end else begin
            mode_nxt = MODE_PLAIN;
            dec_n    = 3'd1;
            dec_b[0] = p_byte_r;
          end
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
      p_vld_r    <= 1'b0;
      mode_r     <= MODE_PLAIN;
      digits_r   <= 3'd0;
      acc_r      <= 32'd0;
      g_cnt_r    <= 3'd0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
      p_vld_r    <= p_vld_nxt;
      if (p_go) begin
        mode_r   <= mode_nxt;
        digits_r <= digits_nxt;
        acc_r    <= acc_nxt;
        g_cnt_r  <= dec_n;
      end else if (out_acc) begin
        g_cnt_r <= g_cnt_r - 3'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && !skid_vld_nxt) begin
      skid_act_r  <= skid_act_r;
      skid_byte_r <= skid_byte_r;
    end else if (in_acc) begin
      skid_act_r  <= in_action;
      skid_byte_r <= in_byte;
    end
    p_act_r  <= p_act_nxt;
    p_byte_r <= p_byte_nxt;
    if (p_go) begin
      g_kind_r <= dec_kind;
      g_err_r  <= dec_err;
      g_b_r[0] <= dec_b[0];
      g_b_r[1] <= dec_b[1];
      g_b_r[2] <= dec_b[2];
      g_b_r[3] <= dec_b[3];
    end else if (out_acc) begin
      // move the next utf-8 beat onto the port
      g_b_r[0] <= g_b_r[1];
      g_b_r[1] <= g_b_r[2];
      g_b_r[2] <= g_b_r[3];
      g_b_r[3] <= 8'd0;
    end
  end

endmodule

`default_nettype wire
